// ----- hw/rtl/ray_sphere_nearest_hit_assert.svh -----
// assertion macros for the ray-sphere nearest hit block
// no dependencies; included by modules that carry assertions
`ifndef RAY_SPHERE_NEAREST_HIT_ASSERT_SVH
`define RAY_SPHERE_NEAREST_HIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RSNH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RSNH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RSNH_ASSERT(lbl, clk, rstn, prop, msg)
`define RSNH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rsnh_pkg.sv -----
// shared constants, types and codes of the ray-sphere nearest hit block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rsnh_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DEPTH_W     = 32;
  localparam int COLOR_W     = 24;
  localparam int CFG_IDX_W   = 2;
  localparam logic [COLOR_W-1:0] BG_RESET = 24'hEC32FF;

  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG    = 2'd3;

  typedef enum logic [1:0] {OP_MUL, OP_SQRT, OP_DIV} unit_op_e;
  typedef enum logic [1:0] {US_IDLE, US_RUN, US_FIN} unit_state_e;
  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} seq_state_e;
  typedef enum logic [1:0] {TG_A, TG_B, TG_C, TG_E} tgt_e;
  typedef enum logic [3:0] {
    ST_DXX, ST_DYY, ST_DZZ, ST_ODX, ST_ODY, ST_ODZ, ST_OXX,
    ST_OYY, ST_OZZ, ST_RR, ST_BB, ST_AC, ST_SQRT, ST_DIV
  } step_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic upd;
    logic hit;
    logic first;
    logic last;
  } hold_req_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rsnh_unit.sv -----
// shared iterative unit: shift-add multiply, digit square root, restoring divide
// depends on rsnh_pkg
`timescale 1ns / 1ps
`default_nettype none
module rsnh_unit #(
  parameter int WW    = 136,
  parameter int CNT_W = 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  rsnh_pkg::unit_req_t    req_i,
  input  wire        [CNT_W-1:0] steps_i,
  input  wire        [WW-1:0]    a_i,
  input  wire        [WW-1:0]    b_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic       [WW-1:0]    res_o
);
  rsnh_pkg::unit_state_e state_q, state_d;
  rsnh_pkg::unit_op_e    op_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [WW-1:0]    acc_q, x_q, y_q, z_q;
  logic [WW-1:0]    p, q, a_abs, b_abs, mul_res;
  logic             sub;
  logic [WW:0]      sum;
  logic             ge;

  assign a_abs   = a_i[WW-1] ? (~a_i + {{(WW-1){1'b0}}, 1'b1}) : a_i;
  assign b_abs   = b_i[WW-1] ? (~b_i + {{(WW-1){1'b0}}, 1'b1}) : b_i;
  assign mul_res = neg_q ? (~acc_q + {{(WW-1){1'b0}}, 1'b1}) : acc_q;

  // the one adder shared by all operations
  always_comb begin
    unique case (op_q)
      rsnh_pkg::OP_SQRT: begin
        p   = {acc_q[WW-3:0], x_q[WW-1:WW-2]};
        q   = {y_q[WW-3:0], 2'b01};
        sub = 1'b1;
      end
      rsnh_pkg::OP_DIV: begin
        p   = {acc_q[WW-2:0], x_q[WW-1]};
        q   = z_q;
        sub = 1'b1;
      end
      default: begin
        p   = acc_q;
        q   = x_q;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, p} + {1'b0, (sub ? ~q : q)} + {{WW{1'b0}}, sub};
    ge  = sum[WW];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsnh_pkg::US_IDLE: if (req_i.start) state_d = rsnh_pkg::US_RUN;
      rsnh_pkg::US_RUN:  if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) state_d = rsnh_pkg::US_FIN;
      rsnh_pkg::US_FIN:  state_d = rsnh_pkg::US_IDLE;
      default:           state_d = rsnh_pkg::US_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsnh_pkg::US_IDLE;
      cnt_q   <= '0;
      op_q    <= rsnh_pkg::OP_MUL;
    end else begin
      state_q <= state_d;
      if (state_q == rsnh_pkg::US_IDLE && req_i.start) begin
        cnt_q <= steps_i;
        op_q  <= req_i.op;
      end else if (state_q == rsnh_pkg::US_RUN) begin
        cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rsnh_pkg::US_IDLE && req_i.start) begin
      acc_q <= '0;
      y_q   <= '0;
      z_q   <= b_i;
      neg_q <= a_i[WW-1] ^ b_i[WW-1];
      if (req_i.op == rsnh_pkg::OP_MUL) begin
        x_q <= a_abs;
        y_q <= b_abs;
      end else begin
        x_q <= a_i;
      end
    end else if (state_q == rsnh_pkg::US_RUN) begin
      unique case (op_q)
        rsnh_pkg::OP_SQRT: begin
          acc_q <= ge ? sum[WW-1:0] : p;
          y_q   <= {y_q[WW-2:0], ge};
          x_q   <= {x_q[WW-3:0], 2'b00};
        end
        rsnh_pkg::OP_DIV: begin
          acc_q <= ge ? sum[WW-1:0] : p;
          y_q   <= {y_q[WW-2:0], ge};
          x_q   <= {x_q[WW-2:0], 1'b0};
        end
        default: begin
          if (y_q[0]) acc_q <= sum[WW-1:0];
          x_q <= {x_q[WW-2:0], 1'b0};
          y_q <= {1'b0, y_q[WW-1:1]};
        end
      endcase
    end
  end

  assign busy_o = (state_q != rsnh_pkg::US_IDLE);
  assign done_o = (state_q == rsnh_pkg::US_FIN);
  assign res_o  = (op_q == rsnh_pkg::OP_MUL) ? mul_res : y_q;
endmodule
`default_nettype wire

// ----- hw/rtl/rsnh_hold.sv -----
// nearest-hit depth test per pixel and the result output register
// depends on rsnh_pkg
`timescale 1ns / 1ps
`default_nettype none
module rsnh_hold (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  rsnh_pkg::hold_req_t                 req_i,
  input  wire        [rsnh_pkg::DEPTH_W-1:0]  depth_i,
  input  wire        [rsnh_pkg::COLOR_W-1:0]  color_i,
  input  wire        [rsnh_pkg::COLOR_W-1:0]  bg_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic                                hit_o,
  output logic       [rsnh_pkg::DEPTH_W-1:0]  depth_o,
  output logic       [rsnh_pkg::COLOR_W-1:0]  pixel_color_o
);
  logic                         any_q, cur_any, take, new_any;
  logic [rsnh_pkg::DEPTH_W-1:0] near_d_q, cur_d, new_d;
  logic [rsnh_pkg::COLOR_W-1:0] near_c_q, new_c;
  logic                         out_valid_q, out_hit_q;
  logic [rsnh_pkg::DEPTH_W-1:0] out_depth_q;
  logic [rsnh_pkg::COLOR_W-1:0] out_color_q;

  always_comb begin
    cur_any = req_i.first ? 1'b0 : any_q;
    cur_d   = req_i.first ? '1 : near_d_q;
    take    = req_i.hit && (!cur_any || (depth_i < cur_d));
    new_any = cur_any || take;
    new_d   = take ? depth_i : cur_d;
    new_c   = take ? color_i : (req_i.first ? '0 : near_c_q);
  end

  assign ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q       <= 1'b0;
      near_d_q    <= '1;
      near_c_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (req_i.upd) begin
        if (req_i.last) begin
          any_q       <= 1'b0;
          near_d_q    <= '1;
          near_c_q    <= '0;
          out_valid_q <= 1'b1;
        end else begin
          any_q    <= new_any;
          near_d_q <= new_d;
          near_c_q <= new_c;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.upd && req_i.last) begin
      out_hit_q   <= new_any;
      out_depth_q <= new_any ? new_d : '1;
      out_color_q <= new_any ? new_c : bg_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign depth_o       = out_depth_q;
  assign pixel_color_o = out_color_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ray_sphere_nearest_hit.sv -----
// top level of the ray-sphere nearest hit block: sequencer, operand registers
// depends on rsnh_pkg, rsnh_unit, rsnh_hold and ray_sphere_nearest_hit_assert.svh
//
// usage
//   request channel: in_valid_i / in_stall_o carries one ray direction and one
//   sphere; first_sphere_i starts a pixel, last_sphere_i closes it
//   result channel: out_valid_o / out_stall_i carries hit, depth and color,
//   one result per pixel, given after the request flagged last
//   config port: cfg_we_i writes cam_x, cam_y, cam_z or background color; the user
//   must write only while the block is idle, as the block itself does not enforce it
//   work per request: the shared multiply/sqrt/divide unit sets how long a request
//   runs from acceptance to the next acceptance: ten short shift-add products, two
//   wide ones, one square root digit per cycle and one quotient bit per cycle; a
//   miss found early skips the square root and the divide, or only the divide
//   in_stall_o is high while a request is being worked on
//   reset: camera at origin, background 236,50,255, nearest-hit state cleared
//   a stalled result is held in the output register; the next request is
//   still taken and runs, and only its pixel's result waits for a free slot
`timescale 1ns / 1ps
`default_nettype none
`include "ray_sphere_nearest_hit_assert.svh"
module ray_sphere_nearest_hit #(
  parameter int COORD_WIDTH = rsnh_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = rsnh_pkg::FRAC_BITS,
  localparam int CFG_W = (COORD_WIDTH > rsnh_pkg::COLOR_W) ? COORD_WIDTH : rsnh_pkg::COLOR_W
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // config write port
  input  wire                                  cfg_we_i,
  input  wire        [rsnh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire        [CFG_W-1:0]               cfg_wdata_i,
  // request channel
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire signed [COORD_WIDTH-1:0]         dir_x_i,
  input  wire signed [COORD_WIDTH-1:0]         dir_y_i,
  input  wire signed [COORD_WIDTH-1:0]         dir_z_i,
  input  wire signed [COORD_WIDTH-1:0]         center_x_i,
  input  wire signed [COORD_WIDTH-1:0]         center_y_i,
  input  wire signed [COORD_WIDTH-1:0]         center_z_i,
  input  wire        [COORD_WIDTH-2:0]         radius_i,
  input  wire        [rsnh_pkg::COLOR_W-1:0]   sphere_color_i,
  input  wire                                  first_sphere_i,
  input  wire                                  last_sphere_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 hit_o,
  output logic       [rsnh_pkg::DEPTH_W-1:0]   depth_o,
  output logic       [rsnh_pkg::COLOR_W-1:0]   pixel_color_o
);
  // dot products fit PW bits signed, the discriminant fits WW
  localparam int PW    = 2 * COORD_WIDTH + 4;
  localparam int WW    = 2 * PW;
  localparam int CNT_W = $clog2(WW + 1);
  localparam int EXT   = WW - COORD_WIDTH;
  localparam logic [CNT_W-1:0] SMALL_N = CNT_W'(COORD_WIDTH + 1);
  localparam logic [CNT_W-1:0] BIG_N   = CNT_W'(PW);
  localparam logic [CNT_W-1:0] SQRT_N  = CNT_W'(WW / 2);
  localparam logic [CNT_W-1:0] DIV_N   = CNT_W'(WW);

  // config registers
  logic [COORD_WIDTH-1:0]       cam_x_q, cam_y_q, cam_z_q;
  logic [rsnh_pkg::COLOR_W-1:0] bg_q;

  // per-request operands and partial results
  logic [WW-1:0] dx_q, dy_q, dz_q, ox_q, oy_q, oz_q, r_q;
  logic [WW-1:0] a_q, b_q, c_q, e_q;
  logic [rsnh_pkg::COLOR_W-1:0] col_q;
  logic                         first_q, last_q, hit_q;
  logic [rsnh_pkg::DEPTH_W-1:0] t_q;

  rsnh_pkg::seq_state_e state_q, state_d;
  rsnh_pkg::step_e      step_q;

  rsnh_pkg::unit_req_t  unit_req;
  rsnh_pkg::hold_req_t  hold_req;
  logic [CNT_W-1:0]     unit_steps;
  logic [WW-1:0]        unit_a, unit_b, unit_res;
  logic                 unit_busy, unit_done;
  logic                 hold_ready;

  logic                 accept, miss;
  rsnh_pkg::tgt_e       wb_tgt;
  logic [WW-1:0]        wb_base, wb_val;
  logic                 wb_sub;
  logic [rsnh_pkg::DEPTH_W-1:0] t_sat;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != rsnh_pkg::S_IDLE);

  // early misses: zero direction, negative discriminant, root not positive
  assign miss = ((step_q == rsnh_pkg::ST_SQRT) && ((a_q == '0) || e_q[WW-1])) ||
                ((step_q == rsnh_pkg::ST_DIV) && (e_q[WW-1] || (e_q == '0)));

  // operand selection for the shared unit
  always_comb begin
    unit_req.op = rsnh_pkg::OP_MUL;
    unit_steps  = SMALL_N;
    unit_a      = dx_q;
    unit_b      = dx_q;
    unique case (step_q)
      rsnh_pkg::ST_DXX: begin unit_a = dx_q; unit_b = dx_q; end
      rsnh_pkg::ST_DYY: begin unit_a = dy_q; unit_b = dy_q; end
      rsnh_pkg::ST_DZZ: begin unit_a = dz_q; unit_b = dz_q; end
      rsnh_pkg::ST_ODX: begin unit_a = dx_q; unit_b = ox_q; end
      rsnh_pkg::ST_ODY: begin unit_a = dy_q; unit_b = oy_q; end
      rsnh_pkg::ST_ODZ: begin unit_a = dz_q; unit_b = oz_q; end
      rsnh_pkg::ST_OXX: begin unit_a = ox_q; unit_b = ox_q; end
      rsnh_pkg::ST_OYY: begin unit_a = oy_q; unit_b = oy_q; end
      rsnh_pkg::ST_OZZ: begin unit_a = oz_q; unit_b = oz_q; end
      rsnh_pkg::ST_RR:  begin unit_a = r_q;  unit_b = r_q;  end
      rsnh_pkg::ST_BB: begin
        unit_a = b_q; unit_b = b_q; unit_steps = BIG_N;
      end
      rsnh_pkg::ST_AC: begin
        unit_a = a_q; unit_b = c_q; unit_steps = BIG_N;
      end
      rsnh_pkg::ST_SQRT: begin
        unit_req.op = rsnh_pkg::OP_SQRT; unit_a = e_q; unit_steps = SQRT_N;
      end
      rsnh_pkg::ST_DIV: begin
        // scaled numerator over a = d.d
        unit_req.op = rsnh_pkg::OP_DIV;
        unit_a      = {e_q[WW-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        unit_b      = a_q;
        unit_steps  = DIV_N;
      end
      default: begin unit_a = dx_q; unit_b = dx_q; end
    endcase
    unit_req.start = (state_q == rsnh_pkg::S_ISSUE) && !miss;
  end

  // write back: set, accumulate or subtract into a, b, c or e
  always_comb begin
    wb_tgt  = rsnh_pkg::TG_A;
    wb_base = '0;
    wb_sub  = 1'b0;
    unique case (step_q)
      rsnh_pkg::ST_DXX: wb_tgt = rsnh_pkg::TG_A;
      rsnh_pkg::ST_DYY,
      rsnh_pkg::ST_DZZ: begin wb_tgt = rsnh_pkg::TG_A; wb_base = a_q; end
      rsnh_pkg::ST_ODX: wb_tgt = rsnh_pkg::TG_B;
      rsnh_pkg::ST_ODY,
      rsnh_pkg::ST_ODZ: begin wb_tgt = rsnh_pkg::TG_B; wb_base = b_q; end
      rsnh_pkg::ST_OXX: wb_tgt = rsnh_pkg::TG_C;
      rsnh_pkg::ST_OYY,
      rsnh_pkg::ST_OZZ: begin wb_tgt = rsnh_pkg::TG_C; wb_base = c_q; end
      rsnh_pkg::ST_RR: begin
        wb_tgt = rsnh_pkg::TG_C; wb_base = c_q; wb_sub = 1'b1;
      end
      rsnh_pkg::ST_BB: wb_tgt = rsnh_pkg::TG_E;
      rsnh_pkg::ST_AC: begin
        wb_tgt = rsnh_pkg::TG_E; wb_base = e_q; wb_sub = 1'b1;
      end
      // e now holds the numerator b - isqrt(disc)
      rsnh_pkg::ST_SQRT: begin
        wb_tgt = rsnh_pkg::TG_E; wb_base = b_q; wb_sub = 1'b1;
      end
      default: wb_tgt = rsnh_pkg::TG_A;
    endcase
    wb_val = wb_base + (wb_sub ? ~unit_res : unit_res) + {{(WW-1){1'b0}}, wb_sub};
  end

  // depth saturates when the quotient overflows 32 bits
  assign t_sat = (|unit_res[WW-1:rsnh_pkg::DEPTH_W]) ? '1 : unit_res[rsnh_pkg::DEPTH_W-1:0];

  always_comb begin
    state_d  = state_q;
    hold_req = '0;
    hold_req.hit   = hit_q;
    hold_req.first = first_q;
    hold_req.last  = last_q;
    unique case (state_q)
      rsnh_pkg::S_IDLE:  if (accept) state_d = rsnh_pkg::S_ISSUE;
      rsnh_pkg::S_ISSUE: state_d = miss ? rsnh_pkg::S_DONE : rsnh_pkg::S_WAIT;
      rsnh_pkg::S_WAIT: begin
        if (unit_done) begin
          state_d = (step_q == rsnh_pkg::ST_DIV) ? rsnh_pkg::S_DONE : rsnh_pkg::S_ISSUE;
        end
      end
      rsnh_pkg::S_DONE: begin
        // a closing request waits here while the output slot is full
        hold_req.upd = !last_q || hold_ready;
        if (hold_req.upd) state_d = rsnh_pkg::S_IDLE;
      end
      default: state_d = rsnh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsnh_pkg::S_IDLE;
      step_q  <= rsnh_pkg::ST_DXX;
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      bg_q    <= rsnh_pkg::BG_RESET;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= rsnh_pkg::ST_DXX;
      end else if (state_q == rsnh_pkg::S_WAIT && unit_done &&
                   step_q != rsnh_pkg::ST_DIV) begin
        step_q <= rsnh_pkg::step_e'(step_q + 4'd1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rsnh_pkg::CFG_CAM_X: cam_x_q <= cfg_wdata_i[COORD_WIDTH-1:0];
          rsnh_pkg::CFG_CAM_Y: cam_y_q <= cfg_wdata_i[COORD_WIDTH-1:0];
          rsnh_pkg::CFG_CAM_Z: cam_z_q <= cfg_wdata_i[COORD_WIDTH-1:0];
          rsnh_pkg::CFG_BG:    bg_q    <= cfg_wdata_i[rsnh_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q    <= {{EXT{dir_x_i[COORD_WIDTH-1]}}, dir_x_i};
      dy_q    <= {{EXT{dir_y_i[COORD_WIDTH-1]}}, dir_y_i};
      dz_q    <= {{EXT{dir_z_i[COORD_WIDTH-1]}}, dir_z_i};
      ox_q    <= {{EXT{center_x_i[COORD_WIDTH-1]}}, center_x_i} -
                 {{EXT{cam_x_q[COORD_WIDTH-1]}}, cam_x_q};
      oy_q    <= {{EXT{center_y_i[COORD_WIDTH-1]}}, center_y_i} -
                 {{EXT{cam_y_q[COORD_WIDTH-1]}}, cam_y_q};
      oz_q    <= {{EXT{center_z_i[COORD_WIDTH-1]}}, center_z_i} -
                 {{EXT{cam_z_q[COORD_WIDTH-1]}}, cam_z_q};
      r_q     <= {{(EXT+1){1'b0}}, radius_i};
      col_q   <= sphere_color_i;
      first_q <= first_sphere_i;
      last_q  <= last_sphere_i;
    end
    if (state_q == rsnh_pkg::S_ISSUE && miss) hit_q <= 1'b0;
    if (state_q == rsnh_pkg::S_WAIT && unit_done) begin
      if (step_q == rsnh_pkg::ST_DIV) begin
        hit_q <= 1'b1;
        t_q   <= t_sat;
      end else begin
        unique case (wb_tgt)
          rsnh_pkg::TG_A: a_q <= wb_val;
          rsnh_pkg::TG_B: b_q <= wb_val;
          rsnh_pkg::TG_C: c_q <= wb_val;
          rsnh_pkg::TG_E: e_q <= wb_val;
          default: ;
        endcase
      end
    end
  end

  rsnh_unit #(
    .WW    (WW),
    .CNT_W (CNT_W)
  ) u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (unit_req),
    .steps_i (unit_steps),
    .a_i     (unit_a),
    .b_i     (unit_b),
    .busy_o  (unit_busy),
    .done_o  (unit_done),
    .res_o   (unit_res)
  );

  rsnh_hold u_hold (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (hold_req),
    .depth_i       (t_q),
    .color_i       (col_q),
    .bg_i          (bg_q),
    .ready_o       (hold_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .depth_o       (depth_o),
    .pixel_color_o (pixel_color_o)
  );

  `RSNH_ASSERT(a_start_idle, clk_i, rst_ni, !unit_req.start || !unit_busy, "unit started while busy")
  `RSNH_ASSERT(a_done_wait, clk_i, rst_ni, !unit_done || (state_q == rsnh_pkg::S_WAIT), "unit done outside wait")
  `RSNH_ASSERT_NEXT(a_accept_issue, clk_i, rst_ni, accept, state_q == rsnh_pkg::S_ISSUE, "request not issued")
  `RSNH_ASSERT(a_out_from_done, clk_i, rst_ni, !$rose(out_valid_o) || $past(state_q == rsnh_pkg::S_DONE && last_q), "result without closing request")
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench for ray_sphere_nearest_hit: directed table, then random pixels
// depends on rsnh_pkg and the ray_sphere_nearest_hit top level
`timescale 1ns / 1ps
module tb;
  import rsnh_pkg::*;

  localparam int LIMIT_CYCLES = 8000000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int RAND_PER_PHASE = 610;
  localparam logic [31:0] DEPTH_INF = 32'hFFFFFFFF;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] dx, dy, dz, cx, cy, cz;
    logic [30:0]        rad;
    logic [23:0]        col;
    logic               first, last;
  } sphere_req_t;

  typedef struct {
    logic        hit;
    logic [31:0] depth;
    logic [23:0] color;
  } pixel_res_t;

  typedef struct {
    sphere_req_t req;
    logic        typed;   // expected result written by hand
    pixel_res_t  res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic signed [31:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [30:0] radius_i = '0;
  logic [23:0] sphere_color_i = '0;
  logic        first_sphere_i = 1'b0, last_sphere_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o;
  logic [31:0] depth_o;
  logic [23:0] pixel_color_o;

  ray_sphere_nearest_hit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .dir_x_i, .dir_y_i, .dir_z_i, .center_x_i, .center_y_i, .center_z_i,
    .radius_i, .sphere_color_i, .first_sphere_i, .last_sphere_i,
    .out_valid_o, .out_stall_i, .hit_o, .depth_o, .pixel_color_o
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the config registers and the per-pixel search state
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [23:0] bg_color;
  logic [31:0] best_depth;
  logic [23:0] best_color;
  logic        best_valid;

  pixel_res_t pending_pixels[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles = 0;

  // floor square root, two bits per step
  function automatic logic [255:0] floor_sqrt(logic [255:0] n);
    logic [255:0] root, rem, bitv;
    root = '0;
    rem  = n;
    for (int pos = 254; pos >= 0; pos -= 2) begin
      bitv = 256'd1 << pos;
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
    end
    return root;
  endfunction

  // near positive root of |o - t*d| = r, exact on wide integers
  function automatic logic ray_hit_depth(sphere_req_t q, output logic [31:0] t);
    wide_t ox, oy, oz, dx, dy, dz, r, a, b, c, e, num;
    logic [255:0] quo;
    dx = q.dx; dy = q.dy; dz = q.dz;
    ox = q.cx; oy = q.cy; oz = q.cz;
    ox = ox - wide_t'(cam_x);
    oy = oy - wide_t'(cam_y);
    oz = oz - wide_t'(cam_z);
    r  = wide_t'({1'b0, q.rad});
    a = dx * dx + dy * dy + dz * dz;
    b = ox * dx + oy * dy + oz * dz;
    c = ox * ox + oy * oy + oz * oz - r * r;
    t = DEPTH_INF;
    if (a == 0) return 1'b0;
    e = b * b - a * c;
    if (e < 0) return 1'b0;
    num = b - wide_t'(floor_sqrt(e));
    if (num <= 0) return 1'b0;
    quo = (256'(num) << FRAC_BITS) / 256'(a);
    t = (quo[255:32] != 0) ? DEPTH_INF : quo[31:0];
    return 1'b1;
  endfunction

  // advance the nearest-hit search by one request; returns 1 when a pixel closes
  function automatic logic track_nearest(sphere_req_t q, output pixel_res_t res);
    logic [31:0] t;
    if (q.first) begin
      best_depth = DEPTH_INF; best_color = '0; best_valid = 1'b0;
    end
    if (ray_hit_depth(q, t) && (!best_valid || t < best_depth)) begin
      best_depth = t; best_color = q.col; best_valid = 1'b1;
    end
    res.hit   = best_valid;
    res.depth = best_valid ? best_depth : DEPTH_INF;
    res.color = best_valid ? best_color : bg_color;
    if (!q.last) return 1'b0;
    best_depth = DEPTH_INF; best_color = '0; best_valid = 1'b0;
    return 1'b1;
  endfunction

  // result side: random stall, compare each accepted pixel with the oldest expectation
  always @(posedge clk_i) begin
    pixel_res_t want;
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel hit %b depth %h color %h",
                 $time, hit_o, depth_o, pixel_color_o);
      end else begin
        want = pending_pixels.pop_front();
        if (hit_o !== want.hit) begin
          errors++;
          $display("%0t: hit exp %b got %b", $time, want.hit, hit_o);
        end
        if (depth_o !== want.depth) begin
          errors++;
          $display("%0t: depth exp %h got %h", $time, want.depth, depth_o);
        end
        if (pixel_color_o !== want.color) begin
          errors++;
          $display("%0t: color exp %h got %h", $time, want.color, pixel_color_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // called at a rising edge; leaves valid high after acceptance so back-to-back
  // requests never drop it within one step
  task automatic send_sphere(sphere_req_t q, logic typed, pixel_res_t typed_res);
    int gap;
    pixel_res_t res;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    dir_x_i        <= q.dx; dir_y_i <= q.dy; dir_z_i <= q.dz;
    center_x_i     <= q.cx; center_y_i <= q.cy; center_z_i <= q.cz;
    radius_i       <= q.rad;
    sphere_color_i <= q.col;
    first_sphere_i <= q.first;
    last_sphere_i  <= q.last;
    do @(posedge clk_i); while (in_stall_o);
    if (track_nearest(q, res)) pending_pixels.push_back(typed ? typed_res : res);
  endtask

  // drop valid, let every pixel out and the last request finish
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CAM_X: cam_x = val;
      CFG_CAM_Y: cam_y = val;
      CFG_CAM_Z: cam_z = val;
      default:   bg_color = val[23:0];
    endcase
  endtask

  function automatic sphere_req_t mk(int dx, int dy, int dz, int cx, int cy, int cz,
                                     int rad, int col, bit first, bit last);
    sphere_req_t q;
    q.dx = dx; q.dy = dy; q.dz = dz; q.cx = cx; q.cy = cy; q.cz = cz;
    q.rad = 31'(rad); q.col = 24'(col); q.first = first; q.last = last;
    return q;
  endfunction

  function automatic pixel_res_t px(bit hit, logic [31:0] depth, logic [23:0] color);
    pixel_res_t r;
    r.hit = hit; r.depth = depth; r.color = color;
    return r;
  endfunction

  // a sphere placed along the ray, or pure noise on any field
  function automatic sphere_req_t rand_sphere(bit first, bit last);
    sphere_req_t q;
    int scale, k;
    if ($urandom_range(99) < 20) begin
      q.dx = $urandom(); q.dy = $urandom(); q.dz = $urandom();
      q.cx = $urandom(); q.cy = $urandom(); q.cz = $urandom();
      q.rad = 31'($urandom());
      q.first = 1'($urandom_range(1)); q.last = 1'($urandom_range(1));
    end else begin
      scale = $urandom_range(1, 4) << 16;
      q.dx = $signed($urandom_range(2 * scale)) - scale;
      q.dy = $signed($urandom_range(2 * scale)) - scale;
      q.dz = $signed($urandom_range(2 * scale)) - scale;
      k = $urandom_range(0, 12);
      q.cx = cam_x + q.dx * k + $signed($urandom_range(4 << 16)) - (2 << 16);
      q.cy = cam_y + q.dy * k + $signed($urandom_range(4 << 16)) - (2 << 16);
      q.cz = cam_z + q.dz * k + $signed($urandom_range(4 << 16)) - (2 << 16);
      q.rad = 31'($urandom_range(3 << 16));
      q.first = first; q.last = last;
    end
    q.col = 24'($urandom());
    return q;
  endfunction

  dir_row_t table_rows[$];

  initial begin
    int n_items, spheres;
    pixel_res_t none;
    none = px(0, '0, '0);
    cam_x = '0; cam_y = '0; cam_z = '0; bg_color = BG_RESET;
    best_depth = DEPTH_INF; best_color = '0; best_valid = 1'b0;

    // one-sphere pixel straight ahead: t = 9.0
    table_rows.push_back('{mk(65536, 0, 0, 10 << 16, 0, 0, 65536, 24'h112233, 1, 1),
                           1, px(1, 9 << 16, 24'h112233)});
    // zero direction is a miss, background after reset
    table_rows.push_back('{mk(0, 0, 0, 10 << 16, 0, 0, 65536, 24'h445566, 1, 1),
                           1, px(0, DEPTH_INF, BG_RESET)});
    // sphere behind the camera
    table_rows.push_back('{mk(65536, 0, 0, -(10 << 16), 0, 0, 65536, 24'h778899, 1, 1),
                           1, px(0, DEPTH_INF, BG_RESET)});
    // three-sphere pixel, the middle one nearest (t = 4.0)
    table_rows.push_back('{mk(65536, 0, 0, 10 << 16, 0, 0, 65536, 24'hAA0000, 1, 0), 0, none});
    table_rows.push_back('{mk(65536, 0, 0, 5 << 16, 0, 0, 65536, 24'h00BB00, 0, 0), 0, none});
    table_rows.push_back('{mk(65536, 0, 0, 20 << 16, 0, 0, 65536, 24'h0000CC, 0, 1),
                           1, px(1, 4 << 16, 24'h00BB00)});
    // equal depths: the first colour stays
    table_rows.push_back('{mk(0, 65536, 0, 0, 6 << 16, 0, 65536, 24'h123456, 1, 0), 0, none});
    table_rows.push_back('{mk(0, 65536, 0, 0, 6 << 16, 0, 65536, 24'h654321, 0, 1),
                           1, px(1, 5 << 16, 24'h123456)});
    // depth overflow saturates, still a hit
    table_rows.push_back('{mk(1, 0, 0, 32'h7FFFFFFF, 0, 0, 65536, 24'hDEAD01, 1, 1),
                           1, px(1, DEPTH_INF, 24'hDEAD01)});
    // saturated first hit kept; an equal saturated hit does not replace it
    table_rows.push_back('{mk(1, 0, 0, 32'h7FFFFFFF, 0, 0, 65536, 24'h0F0F0F, 1, 0), 0, none});
    table_rows.push_back('{mk(0, 1, 0, 0, 32'h7FFFFFFF, 0, 65536, 24'hF0F0F0, 0, 1),
                           1, px(1, DEPTH_INF, 24'h0F0F0F)});
    // tiny root below one depth step gives depth 0
    table_rows.push_back('{mk(32'h7FFFFFFF, 0, 0, 2, 0, 0, 1, 24'h00FF00, 1, 1),
                           1, px(1, 0, 24'h00FF00)});
    // field extremes
    table_rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 1, 1),
                           0, none});
    table_rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 0, 0, 1, 1), 0, none});
    table_rows.push_back('{mk(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF,
                              24'hABCDEF, 1, 1), 0, none});
    // pixel after an emission with no first flag starts clean
    table_rows.push_back('{mk(0, 0, 65536, 0, 0, 3 << 16, 65536, 24'h135790, 0, 1),
                           1, px(1, 2 << 16, 24'h135790)});
    // restart in mid pixel drops the earlier nearer hit
    table_rows.push_back('{mk(65536, 0, 0, 2 << 16, 0, 0, 65536, 24'h222222, 1, 0), 0, none});
    table_rows.push_back('{mk(65536, 0, 0, 8 << 16, 0, 0, 65536, 24'h333333, 1, 1),
                           1, px(1, 7 << 16, 24'h333333)});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) send_sphere(table_rows[i].req, table_rows[i].typed,
                                        table_rows[i].res);

    // three phases: receiver idles more, sender idles more, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          tx_idle_pct = 28; rx_idle_pct = 86;
          write_reg(CFG_CAM_X, $urandom_range(8 << 16));
          write_reg(CFG_CAM_Y, -$urandom_range(8 << 16));
          write_reg(CFG_CAM_Z, 0);
          write_reg(CFG_BG, 0);
        end
        1: begin
          tx_idle_pct = 86; rx_idle_pct = 28;
          write_reg(CFG_CAM_X, 32'h80000000);
          write_reg(CFG_CAM_Y, 32'h7FFFFFFF);
          write_reg(CFG_CAM_Z, 32'h80000000);
          write_reg(CFG_BG, 32'h00FFFFFF);
        end
        default: begin
          tx_idle_pct = 0; rx_idle_pct = 0;
          write_reg(CFG_CAM_X, $urandom());
          write_reg(CFG_CAM_Y, $urandom());
          write_reg(CFG_CAM_Z, $signed($urandom_range(16 << 16)) - (8 << 16));
          write_reg(CFG_BG, $urandom());
        end
      endcase
      n_items = 0;
      while (n_items < RAND_PER_PHASE) begin
        spheres = $urandom_range(1, 4);
        for (int s = 0; s < spheres; s++) begin
          send_sphere(rand_sphere(s == 0, s == spheres - 1), 1'b0, none);
          n_items++;
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
